// ===== src/uarp_pkg.sv =====
// Package for the UWB ASCII range report parser: character codes and record offsets.
package uarp_pkg;

	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_ONE   = 8'h31;

	localparam logic [3:0] OFS_ID    = 4'd10;
	localparam logic [3:0] OFS_VALUE = 4'd12;

endpackage

// ===== src/uarp_rx_if.sv =====
// Receive byte channel: one word is one ASCII byte plus its end-of-buffer mark.
interface uarp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_in_buffer;

	modport source (output valid, output data_byte, output last_in_buffer, input ready);
	modport sink   (input valid, input data_byte, input last_in_buffer, output ready);
endinterface

// ===== src/uarp_report_if.sv =====
// Report channel: one word is one parser result.
interface uarp_report_if #(
	parameter int DISTANCE_BITS = 20
);
	logic                     valid;
	logic                     ready;
	logic                     record_done;
	logic [2:0]               anchor_id;
	logic [DISTANCE_BITS-1:0] distance_cm;
	logic                     record_error;
	logic                     buffer_done;
	logic                     all_present;

	modport source (
		output valid, output record_done, output anchor_id, output distance_cm,
		output record_error, output buffer_done, output all_present, input ready
	);
	modport sink (
		input valid, input record_done, input anchor_id, input distance_cm,
		input record_error, input buffer_done, input all_present, output ready
	);
endinterface

// ===== src/uwb_ascii_range_report_parser_unit.sv =====
// A result is registered when its byte is accepted on rx: into the output register, or into the skid
// if the output holds a word that is not being taken. Throughput: one byte per cycle while the skid is
// empty; the per-byte update of offset, accumulator and anchor registers is a single registered pass,
// and a one-word skid behind the output register keeps rx open while one result waits to be taken.
// Reset (arst_n low, asynchronous): no record open, all anchor distances zero,
// output and skid empty.
module uwb_ascii_range_report_parser_unit #(
	parameter int NUM_ANCHORS   = 4,
	parameter int DISTANCE_BITS = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	uarp_rx_if.sink              rx,
	uarp_report_if.source        report
);

	localparam int ACC_W = DISTANCE_BITS + 4;
	localparam logic [DISTANCE_BITS-1:0] DIST_MAX = {DISTANCE_BITS{1'b1}};
	localparam logic [7:0] ID_HI = 8'(int'(uarp_pkg::CH_ZERO) + NUM_ANCHORS);

	// record state
	logic                     in_record_q;
	logic [3:0]               ofs_q;
	logic [7:0]               id_q;
	logic [DISTANCE_BITS-1:0] acc_q;
	logic                     bad_q;
	logic [DISTANCE_BITS-1:0] dist_q [NUM_ANCHORS];

	// next state
	logic                     in_record_n;
	logic [3:0]               ofs_n;
	logic [3:0]               ofs_inc;
	logic [7:0]               id_n;
	logic [DISTANCE_BITS-1:0] acc_n;
	logic                     bad_n;
	logic [DISTANCE_BITS-1:0] dist_n [NUM_ANCHORS];
	logic [ACC_W-1:0]         acc_mul;

	// result
	logic                     emit;
	logic                     r_done;
	logic [2:0]               r_aid;
	logic [DISTANCE_BITS-1:0] r_dist;
	logic                     r_err;
	logic                     r_bdone;
	logic                     r_allp;
	logic                     id_ok;
	logic                     accept;

	// output register and skid
	logic                     out_v_q;
	logic                     out_done_q;
	logic [2:0]               out_aid_q;
	logic [DISTANCE_BITS-1:0] out_dist_q;
	logic                     out_err_q;
	logic                     out_bdone_q;
	logic                     out_allp_q;
	logic                     skid_v_q;
	logic                     skid_done_q;
	logic [2:0]               skid_aid_q;
	logic [DISTANCE_BITS-1:0] skid_dist_q;
	logic                     skid_err_q;
	logic                     skid_bdone_q;
	logic                     skid_allp_q;
	logic                     out_take;

	assign rx.ready = !skid_v_q;
	assign accept   = rx.valid && rx.ready;
	assign out_take = out_v_q && report.ready;

	assign id_ok   = (id_q >= uarp_pkg::CH_ONE) && (id_q <= ID_HI);
	assign ofs_inc = (ofs_q >= uarp_pkg::OFS_VALUE) ? uarp_pkg::OFS_VALUE : ofs_q + 4'd1;
	assign acc_mul = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1)
		+ {{(ACC_W-4){1'b0}}, rx.data_byte[3:0]};

	always_comb begin
		in_record_n = in_record_q;
		ofs_n       = ofs_q;
		id_n        = id_q;
		acc_n       = acc_q;
		bad_n       = bad_q;
		emit        = 1'b0;
		r_done      = 1'b0;
		r_aid       = 3'd0;
		r_dist      = '0;
		r_err       = 1'b0;
		r_bdone     = 1'b0;
		r_allp      = 1'b0;
		if (rx.data_byte == uarp_pkg::CH_START) begin
			in_record_n = 1'b1;
			ofs_n       = 4'd0;
			id_n        = 8'd0;
			acc_n       = '0;
			bad_n       = 1'b0;
		end else if (in_record_q) begin
			ofs_n = ofs_inc;
			if (ofs_inc == uarp_pkg::OFS_ID) begin
				id_n = rx.data_byte;
			end else if (ofs_inc > uarp_pkg::OFS_ID && rx.data_byte == uarp_pkg::CH_CR) begin
				emit        = 1'b1;
				in_record_n = 1'b0;
				if (!bad_q && id_ok) begin
					r_done = 1'b1;
					r_aid  = 3'(id_q - uarp_pkg::CH_ZERO);
					r_dist = acc_q;
				end else begin
					r_err = 1'b1;
				end
			end else if (ofs_inc == uarp_pkg::OFS_VALUE) begin
				if (rx.data_byte == uarp_pkg::CH_DOT) begin
					// skip decimal point
				end else if (rx.data_byte >= uarp_pkg::CH_ZERO
						&& rx.data_byte <= uarp_pkg::CH_NINE) begin
					acc_n = (acc_mul > {4'd0, DIST_MAX}) ? DIST_MAX
						: acc_mul[DISTANCE_BITS-1:0];
				end else begin
					bad_n = 1'b1;
				end
			end
		end
		// store into the addressed anchor before the presence check
		for (int k = 0; k < NUM_ANCHORS; k++) begin
			dist_n[k] = (r_done && id_q == 8'(int'(uarp_pkg::CH_ONE) + k)) ? acc_q : dist_q[k];
		end
		if (rx.last_in_buffer) begin
			emit        = 1'b1;
			in_record_n = 1'b0;
			r_bdone     = 1'b1;
			r_allp      = 1'b1;
			for (int k = 0; k < NUM_ANCHORS; k++) begin
				if (dist_n[k] == '0) r_allp = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_record_q <= 1'b0;
			ofs_q       <= 4'd0;
			id_q        <= 8'd0;
			acc_q       <= '0;
			bad_q       <= 1'b0;
			for (int k = 0; k < NUM_ANCHORS; k++) dist_q[k] <= '0;
		end else if (accept) begin
			in_record_q <= in_record_n;
			ofs_q       <= ofs_n;
			id_q        <= id_n;
			acc_q       <= acc_n;
			bad_q       <= bad_n;
			for (int k = 0; k < NUM_ANCHORS; k++) dist_q[k] <= dist_n[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			// drain skid into the output register
			if (out_take) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (accept && emit) begin
			if (!out_v_q || out_take) out_v_q <= 1'b1;
			else skid_v_q <= 1'b1;
		end else if (out_take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_take) begin
				out_done_q  <= skid_done_q;
				out_aid_q   <= skid_aid_q;
				out_dist_q  <= skid_dist_q;
				out_err_q   <= skid_err_q;
				out_bdone_q <= skid_bdone_q;
				out_allp_q  <= skid_allp_q;
			end
		end else if (accept && emit) begin
			if (!out_v_q || out_take) begin
				out_done_q  <= r_done;
				out_aid_q   <= r_aid;
				out_dist_q  <= r_dist;
				out_err_q   <= r_err;
				out_bdone_q <= r_bdone;
				out_allp_q  <= r_allp;
			end else begin
				skid_done_q  <= r_done;
				skid_aid_q   <= r_aid;
				skid_dist_q  <= r_dist;
				skid_err_q   <= r_err;
				skid_bdone_q <= r_bdone;
				skid_allp_q  <= r_allp;
			end
		end
	end

	assign report.valid        = out_v_q;
	assign report.record_done  = out_done_q;
	assign report.anchor_id    = out_aid_q;
	assign report.distance_cm  = out_dist_q;
	assign report.record_error = out_err_q;
	assign report.buffer_done  = out_bdone_q;
	assign report.all_present  = out_allp_q;

endmodule

// ===== tb/uwb_ascii_range_report_parser_unit_test.sv =====
// Self-checking testbench for the UWB ASCII range report parser: directed records, then random streams.
`timescale 1ns / 1ps

module uwb_ascii_range_report_parser_unit_test;

	localparam int NUM_ANCHORS = 4;
	localparam int DIST_W      = 20;
	localparam int unsigned DIST_MAX = (1 << DIST_W) - 1;
	localparam int RANDOM_BYTES = 1700;

	typedef struct packed {
		logic              record_done;
		logic [2:0]        anchor_id;
		logic [DIST_W-1:0] distance_cm;
		logic              record_error;
		logic              buffer_done;
		logic              all_present;
	} range_result_t;

	logic clk = 1'b0;
	logic arst_n;

	uarp_rx_if rx ();
	uarp_report_if #(.DISTANCE_BITS(DIST_W)) report ();

	uwb_ascii_range_report_parser_unit #(
		.NUM_ANCHORS  (NUM_ANCHORS),
		.DISTANCE_BITS(DIST_W)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx),
		.report(report)
	);

	always #5 clk = ~clk;

	// parser state as tracked by the testbench
	logic              rec_open   = 1'b0;
	logic [3:0]        rec_ofs    = '0;
	logic [7:0]        rec_id     = '0;
	logic [DIST_W-1:0] rec_value  = '0;
	logic              rec_bad    = 1'b0;
	logic [DIST_W-1:0] anchor_dist [NUM_ANCHORS];

	range_result_t pending_reports [$];
	logic [7:0]    frame_bytes [$];
	int            mismatch_count = 0;
	bit            rx_gaps_on     = 1'b1;
	bit            rpt_stalls_on  = 1'b1;
	bit            stray_last_en  = 1'b0;

	initial begin
		for (int k = 0; k < NUM_ANCHORS; k++)
			anchor_dist[k] = '0;
	end

	task automatic flag_mismatch(input string what, input longint want, input longint got);
		$display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
		mismatch_count++;
	endtask

	// Advance the tracked parser by one byte; return 1 when a result word is due.
	function automatic bit predict_range_report(input logic [7:0] b, input logic last,
		output range_result_t res);
		bit          emit;
		logic [3:0]  ofs;
		int unsigned idx;
		int unsigned nxt;
		emit = 1'b0;
		res  = '0;
		if (b == uarp_pkg::CH_START) begin
			rec_open  = 1'b1;
			rec_ofs   = '0;
			rec_id    = '0;
			rec_value = '0;
			rec_bad   = 1'b0;
		end else if (rec_open) begin
			ofs = (rec_ofs >= uarp_pkg::OFS_VALUE) ? uarp_pkg::OFS_VALUE : rec_ofs + 4'd1;
			rec_ofs = ofs;
			if (ofs == uarp_pkg::OFS_ID) begin
				rec_id = b;
			end else if (ofs > uarp_pkg::OFS_ID && b == uarp_pkg::CH_CR) begin
				emit = 1'b1;
				if (!rec_bad && rec_id >= uarp_pkg::CH_ONE
						&& int'(rec_id) <= int'(uarp_pkg::CH_ZERO) + NUM_ANCHORS) begin
					idx = int'(rec_id - uarp_pkg::CH_ONE);
					anchor_dist[idx] = rec_value;
					res.record_done  = 1'b1;
					res.anchor_id    = 3'(idx + 1);
					res.distance_cm  = rec_value;
				end else begin
					res.record_error = 1'b1;
				end
				rec_open = 1'b0;
			end else if (ofs == uarp_pkg::OFS_VALUE) begin
				if (b == uarp_pkg::CH_DOT) begin
					// skip the decimal point
				end else if (b >= uarp_pkg::CH_ZERO && b <= uarp_pkg::CH_NINE) begin
					nxt = int'(rec_value) * 10 + int'(b - uarp_pkg::CH_ZERO);
					rec_value = (nxt > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(nxt);
				end else begin
					rec_bad = 1'b1;
				end
			end
		end
		if (last) begin
			emit = 1'b1;
			rec_open = 1'b0;
			res.buffer_done = 1'b1;
			res.all_present = 1'b1;
			for (int k = 0; k < NUM_ANCHORS; k++)
				if (anchor_dist[k] == '0)
					res.all_present = 1'b0;
		end
		return emit;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		int            gap;
		range_result_t res;
		gap = rx_gaps_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			rx.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx.valid          <= 1'b1;
		rx.data_byte      <= b;
		rx.last_in_buffer <= last;
		do @(posedge clk); while (rx.ready !== 1'b1);
		if (predict_range_report(b, last, res))
			pending_reports.push_back(res);
	endtask

	task automatic send_frame(input bit last_at_end);
		logic last;
		for (int i = 0; i < frame_bytes.size(); i++) begin
			last = (last_at_end && i == frame_bytes.size() - 1) ||
				(stray_last_en && $urandom_range(0, 99) == 0);
			send_byte(frame_bytes[i], last);
		end
		frame_bytes.delete();
	endtask

	function automatic logic [7:0] rand_filler(input bit allow_cr);
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == uarp_pkg::CH_START || (!allow_cr && b == uarp_pkg::CH_CR));
		return b;
	endfunction

	// '$' and offsets 1 to 9
	task automatic add_lead();
		frame_bytes.push_back(uarp_pkg::CH_START);
		repeat (9) frame_bytes.push_back(rand_filler(1'b1));
	endtask

	// lead, id byte, and the ignored byte at offset 11
	task automatic add_prefix(input logic [7:0] id);
		add_lead();
		frame_bytes.push_back(id);
		frame_bytes.push_back(rand_filler(1'b0));
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			frame_bytes.push_back(8'(s[i]));
	endtask

	task automatic add_digits(input int n);
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(0, 4) == 0)
				frame_bytes.push_back(uarp_pkg::CH_DOT);
			frame_bytes.push_back(uarp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
		end
	endtask

	function automatic int rand_digit_count();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 6);
	endfunction

	task automatic test_idle_bytes();
		frame_bytes.push_back(8'h00);
		frame_bytes.push_back(8'hFF);
		frame_bytes.push_back(uarp_pkg::CH_CR);
		frame_bytes.push_back(8'h7F);
		send_frame(1'b1);
	endtask

	task automatic test_good_records();
		add_prefix(uarp_pkg::CH_ONE);
		add_text("12.34");
		frame_bytes.push_back(uarp_pkg::CH_CR);
		add_prefix(uarp_pkg::CH_ONE + 8'd1);
		add_text("0.01");
		frame_bytes.push_back(uarp_pkg::CH_CR);
		add_prefix(uarp_pkg::CH_ONE + 8'd2);
		add_text("999.99");
		frame_bytes.push_back(uarp_pkg::CH_CR);
		// CR on the last byte: record and buffer close in one word
		add_prefix(uarp_pkg::CH_ONE + 8'd3);
		add_text("10485.75");
		frame_bytes.push_back(uarp_pkg::CH_CR);
		send_frame(1'b1);
	endtask

	task automatic test_saturation();
		add_prefix(uarp_pkg::CH_ONE + 8'd1);
		add_text("99999999");
		frame_bytes.push_back(uarp_pkg::CH_CR);
		send_frame(1'b0);
	endtask

	task automatic test_zero_distance();
		// CR right after the id closes with distance zero
		add_lead();
		frame_bytes.push_back(uarp_pkg::CH_ONE + 8'd2);
		frame_bytes.push_back(uarp_pkg::CH_CR);
		frame_bytes.push_back(8'h41);
		send_frame(1'b1);
	endtask

	task automatic test_bad_ids();
		add_prefix(uarp_pkg::CH_ZERO);
		add_text("5");
		frame_bytes.push_back(uarp_pkg::CH_CR);
		add_prefix(uarp_pkg::CH_ONE + 8'(NUM_ANCHORS));
		add_text("5");
		frame_bytes.push_back(uarp_pkg::CH_CR);
		add_prefix(8'hFF);
		frame_bytes.push_back(uarp_pkg::CH_CR);
		// CR in the id slot is taken as the id
		add_lead();
		frame_bytes.push_back(uarp_pkg::CH_CR);
		frame_bytes.push_back(uarp_pkg::CH_CR);
		send_frame(1'b0);
	endtask

	task automatic test_bad_char();
		add_prefix(uarp_pkg::CH_ONE);
		add_text("12a3");
		frame_bytes.push_back(uarp_pkg::CH_CR);
		send_frame(1'b0);
	endtask

	task automatic test_dollar_restart();
		add_prefix(uarp_pkg::CH_ONE + 8'd3);
		add_text("55");
		add_prefix(uarp_pkg::CH_ONE + 8'd3);
		add_text("66");
		frame_bytes.push_back(uarp_pkg::CH_CR);
		send_frame(1'b0);
	endtask

	task automatic test_open_at_end();
		add_prefix(uarp_pkg::CH_ONE);
		add_text("77");
		send_frame(1'b1);
		frame_bytes.push_back(uarp_pkg::CH_START);
		send_frame(1'b1);
	endtask

	task automatic test_random_stream();
		int         counted;
		int         kind;
		int         n;
		logic [7:0] b;
		counted = 0;
		stray_last_en = 1'b1;
		while (counted < RANDOM_BYTES) begin
			if ($urandom_range(0, 7) == 0) rx_gaps_on = ~rx_gaps_on;
			if ($urandom_range(0, 7) == 0) rpt_stalls_on = ~rpt_stalls_on;
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				add_prefix(uarp_pkg::CH_ONE + 8'($urandom_range(0, NUM_ANCHORS - 1)));
				add_digits(rand_digit_count());
				frame_bytes.push_back(uarp_pkg::CH_CR);
			end else if (kind < 67) begin
				do b = 8'($urandom_range(0, 255));
				while (b >= uarp_pkg::CH_ONE
					&& int'(b) <= int'(uarp_pkg::CH_ZERO) + NUM_ANCHORS);
				add_prefix(b);
				add_digits(rand_digit_count());
				frame_bytes.push_back(uarp_pkg::CH_CR);
			end else if (kind < 73) begin
				add_prefix(uarp_pkg::CH_ONE + 8'($urandom_range(0, NUM_ANCHORS - 1)));
				add_digits($urandom_range(0, 3));
				do b = rand_filler(1'b0);
				while (b == uarp_pkg::CH_DOT
					|| (b >= uarp_pkg::CH_ZERO && b <= uarp_pkg::CH_NINE));
				frame_bytes.push_back(b);
				add_digits($urandom_range(0, 3));
				frame_bytes.push_back(uarp_pkg::CH_CR);
			end else if (kind < 78) begin
				// cut short; the next '$' or a buffer end abandons it
				frame_bytes.push_back(uarp_pkg::CH_START);
				n = $urandom_range(0, 14);
				repeat (n) frame_bytes.push_back(rand_filler(1'b0));
			end else if (kind < 82) begin
				add_lead();
				if ($urandom_range(0, 1))
					frame_bytes.push_back(uarp_pkg::CH_ONE
						+ 8'($urandom_range(0, NUM_ANCHORS - 1)));
				frame_bytes.push_back(uarp_pkg::CH_CR);
			end else if (kind < 88) begin
				n = $urandom_range(1, 4);
				repeat (n) frame_bytes.push_back(rand_filler(1'b1));
				send_frame($urandom_range(0, 2) == 0);
				continue;
			end else if (kind < 94) begin
				add_prefix(uarp_pkg::CH_ONE + 8'($urandom_range(0, NUM_ANCHORS - 1)));
				add_digits($urandom_range(0, 5));
				counted += frame_bytes.size();
				send_frame(1'b1);
				continue;
			end else begin
				add_prefix(uarp_pkg::CH_ONE + 8'($urandom_range(0, NUM_ANCHORS - 1)));
				add_digits(rand_digit_count());
				frame_bytes.push_back(uarp_pkg::CH_CR);
				counted += frame_bytes.size();
				send_frame(1'b1);
				continue;
			end
			counted += frame_bytes.size();
			send_frame($urandom_range(0, 11) == 0);
		end
		stray_last_en = 1'b0;
	endtask

	// report side: random stalls, compare each word with the oldest prediction
	initial begin : report_sink
		range_result_t got;
		range_result_t want;
		int            stall;
		report.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rpt_stalls_on ? $urandom_range(0, 11) : 0;
			if (stall > 0) begin
				report.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			report.ready <= 1'b1;
			do @(posedge clk); while (report.valid !== 1'b1);
			got = '{report.record_done, report.anchor_id, report.distance_cm,
				report.record_error, report.buffer_done, report.all_present};
			if (pending_reports.size() == 0) begin
				flag_mismatch("unexpected result word", 0, 1);
			end else begin
				want = pending_reports.pop_front();
				if (got.record_done !== want.record_done)
					flag_mismatch("record_done", want.record_done, got.record_done);
				if (got.anchor_id !== want.anchor_id)
					flag_mismatch("anchor_id", want.anchor_id, got.anchor_id);
				if (got.distance_cm !== want.distance_cm)
					flag_mismatch("distance_cm", want.distance_cm, got.distance_cm);
				if (got.record_error !== want.record_error)
					flag_mismatch("record_error", want.record_error, got.record_error);
				if (got.buffer_done !== want.buffer_done)
					flag_mismatch("buffer_done", want.buffer_done, got.buffer_done);
				if (got.all_present !== want.all_present)
					flag_mismatch("all_present", want.all_present, got.all_present);
			end
		end
	end

	initial begin : run_tests
		int waited;
		arst_n            <= 1'b0;
		rx.valid          <= 1'b0;
		rx.data_byte      <= '0;
		rx.last_in_buffer <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_idle_bytes();
		test_good_records();
		test_saturation();
		test_zero_distance();
		test_bad_ids();
		test_bad_char();
		test_dollar_restart();
		test_open_at_end();
		test_random_stream();

		rx.valid <= 1'b0;
		waited = 0;
		while (pending_reports.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (pending_reports.size() != 0)
			flag_mismatch("outstanding result words", 0, pending_reports.size());
		if (mismatch_count == 0) begin
			$display("uwb_ascii_range_report_parser_unit_test passed");
		end else begin
			$display("uwb_ascii_range_report_parser_unit_test failed");
		end
		$finish;
	end

	initial begin : run_limit
		#5ms;
		$display("uwb_ascii_range_report_parser_unit_test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/uarp_pkg.sv
src/uarp_rx_if.sv
src/uarp_report_if.sv
src/uwb_ascii_range_report_parser_unit.sv
tb/uwb_ascii_range_report_parser_unit_test.sv
